// ===== hdl/lfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfc_pkg: shared definitions for the IR remote LED fade controller.
// Holds the remote codes, the level constants, register indexes and types.
// ----------------------------------------------------------------------------
package lfc_pkg;

  // Widths of the fixed fields.
  localparam int COLOR_W   = 24;
  localparam int CHAN_W    = 8;
  localparam int CODE_W    = 32;
  localparam int CFG_IDX_W = 8;

  // Decoded remote button codes.
  localparam logic [CODE_W-1:0] CODE_OFF   = 32'hFD02EF00;
  localparam logic [CODE_W-1:0] CODE_SOLID = 32'hF40BEF00;
  localparam logic [CODE_W-1:0] CODE_FADE  = 32'hF00FEF00;
  localparam logic [CODE_W-1:0] CODE_RED   = 32'hFB04EF00;
  localparam logic [CODE_W-1:0] CODE_GREEN = 32'hFA05EF00;
  localparam logic [CODE_W-1:0] CODE_BLUE  = 32'hF906EF00;
  localparam logic [CODE_W-1:0] CODE_WHITE = 32'hF807EF00;
  localparam logic [CODE_W-1:0] CODE_ON    = 32'hFC03EF00;

  // Fade level limits and step size.
  localparam logic [CHAN_W-1:0] LEVEL_MAX  = 8'd255;
  localparam logic [CHAN_W-1:0] LEVEL_STEP = 8'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RED   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE = 8'd3;

  // Reset values of the color registers and the chosen color.
  localparam logic [COLOR_W-1:0] RESET_RED   = 24'hFF0000;
  localparam logic [COLOR_W-1:0] RESET_GREEN = 24'h00FF00;
  localparam logic [COLOR_W-1:0] RESET_BLUE  = 24'h0000FF;
  localparam logic [COLOR_W-1:0] RESET_WHITE = 24'hFFFFFF;

  // Request type codes.
  localparam logic REQ_TICK = 1'b0;

  // The four configured colors as seen by the core.
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] white;
  } color_set_t;

  // One result item.
  typedef struct packed {
    logic              frame_valid;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              lamp_is_on;
    logic              fade_active;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/ir_remote_led_fade_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ir_remote_led_fade_controller: lamp color controller for ticks and IR codes.
// An item passes through the input register, then the result register; a full
// result register that is not drained holds the item in the input register.
// Throughput: one item per cycle while the result side drains, set by the single
// combinational pass of the core with its 8x8 channel multipliers.
// Reset (synchronous, active high) empties both stages, turns the lamp off in
// solid mode at level 255 dimming, chosen color red, colors at defaults.
// ----------------------------------------------------------------------------
module ir_remote_led_fade_controller (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          req_type,
  input  wire logic [lfc_pkg::CODE_W-1:0]    ir_code,
  // Result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               frame_valid,
  output logic [lfc_pkg::CHAN_W-1:0]         red_out,
  output logic [lfc_pkg::CHAN_W-1:0]         green_out,
  output logic [lfc_pkg::CHAN_W-1:0]         blue_out,
  output logic                               lamp_is_on,
  output logic                               fade_active,
  // Configuration channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lfc_pkg::COLOR_W-1:0]   cfg_data
);

  // Input stage registers.
  logic                       in_full;
  logic                       in_req_type;
  logic [lfc_pkg::CODE_W-1:0] in_code;

  // Result stage registers.
  logic                       res_full;
  lfc_pkg::result_t           res;

  lfc_pkg::color_set_t        colors;
  lfc_pkg::result_t           core_result;
  logic                       advance;

  assign cfg_ready = 1'b1;

  // The held item moves on whenever the result stage is empty or draining.
  assign advance  = in_full && (!res_full || out_ready);
  assign in_ready = !in_full || advance;

  lfc_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .colors   (colors)
  );

  lfc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .req_type (in_req_type),
    .ir_code  (in_code),
    .colors   (colors),
    .result   (core_result)
  );

  // Input register: capture on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
    if (in_valid && in_ready) begin
      in_req_type <= req_type;
      in_code     <= ir_code;
    end
  end

  // Result register: loaded as the core finishes an item.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_full <= 1'b0;
    end else if (advance) begin
      res_full <= 1'b1;
    end else if (out_ready) begin
      res_full <= 1'b0;
    end
    if (advance) begin
      res <= core_result;
    end
  end

  assign out_valid   = res_full;
  assign frame_valid = res.frame_valid;
  assign red_out     = res.red_out;
  assign green_out   = res.green_out;
  assign blue_out    = res.blue_out;
  assign lamp_is_on  = res.lamp_is_on;
  assign fade_active = res.fade_active;

endmodule
`default_nettype wire

// ===== hdl/lfc_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfc_cfg_regs: configuration color registers.
// Four 24-bit colors written through the configuration port; writes to an
// unknown index are dropped.
// ----------------------------------------------------------------------------
module lfc_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [lfc_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [lfc_pkg::COLOR_W-1:0]   wr_data,
  output lfc_pkg::color_set_t                colors
);

  lfc_pkg::color_set_t regs;

  // Register file update on each configuration transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.red   <= lfc_pkg::RESET_RED;
      regs.green <= lfc_pkg::RESET_GREEN;
      regs.blue  <= lfc_pkg::RESET_BLUE;
      regs.white <= lfc_pkg::RESET_WHITE;
    end else if (wr_en) begin
      unique case (wr_index)
        lfc_pkg::REG_RED:   regs.red   <= wr_data;
        lfc_pkg::REG_GREEN: regs.green <= wr_data;
        lfc_pkg::REG_BLUE:  regs.blue  <= wr_data;
        lfc_pkg::REG_WHITE: regs.white <= wr_data;
        default: ;
      endcase
    end
  end

  assign colors = regs;

endmodule
`default_nettype wire

// ===== hdl/lfc_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lfc_core: lamp state and fill color computation.
// Decodes remote codes, holds power, mode, fade level and chosen color, and
// forms the result of one item in a single combinational pass.
// ----------------------------------------------------------------------------
module lfc_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       fire,
  input  wire logic                       req_type,
  input  wire logic [lfc_pkg::CODE_W-1:0] ir_code,
  input  wire lfc_pkg::color_set_t        colors,
  output lfc_pkg::result_t                result
);

  localparam int CW = lfc_pkg::CHAN_W;

  // Lamp state registers.
  logic                        lamp_power, lamp_power_next;
  logic                        mode_fade, mode_fade_next;
  logic [CW-1:0]               fade_level, fade_level_next;
  logic                        going_down, going_down_next;
  logic [lfc_pkg::COLOR_W-1:0] chosen_color, chosen_color_next;

  logic          tick;
  logic [CW-1:0] chan_r, chan_g, chan_b;
  logic [CW-1:0] scaled_r, scaled_g, scaled_b;
  logic [CW-1:0] stepped;

  // Scale one channel by level/255 with truncation. For every 8x8 product
  // (at most 255*255) the quotient by 255 equals (x + (x >> 8) + 1) >> 8.
  function automatic logic [CW-1:0] scale_chan(input logic [CW-1:0] c,
                                               input logic [CW-1:0] lvl);
    logic [2*CW-1:0] prod;
    logic [2*CW:0]   sum;
    prod = c * lvl;
    sum  = {1'b0, prod} + {{(CW+1){1'b0}}, prod[2*CW-1:CW]} + 1'b1;
    return sum[2*CW-1:CW];
  endfunction

  assign tick   = (req_type == lfc_pkg::REQ_TICK);
  assign chan_r = chosen_color[3*CW-1:2*CW];
  assign chan_g = chosen_color[2*CW-1:CW];
  assign chan_b = chosen_color[CW-1:0];

  assign scaled_r = scale_chan(chan_r, fade_level);
  assign scaled_g = scale_chan(chan_g, fade_level);
  assign scaled_b = scale_chan(chan_b, fade_level);

  // Saturating level step in the current direction.
  always_comb begin
    if (going_down) begin
      stepped = (fade_level < lfc_pkg::LEVEL_STEP) ? '0 : fade_level - lfc_pkg::LEVEL_STEP;
    end else begin
      stepped = (fade_level > (lfc_pkg::LEVEL_MAX - lfc_pkg::LEVEL_STEP)) ?
                lfc_pkg::LEVEL_MAX : fade_level + lfc_pkg::LEVEL_STEP;
    end
  end

  // Next state and result of the current item.
  always_comb begin
    lamp_power_next   = lamp_power;
    mode_fade_next    = mode_fade;
    fade_level_next   = fade_level;
    going_down_next   = going_down;
    chosen_color_next = chosen_color;
    result.red_out    = '0;
    result.green_out  = '0;
    result.blue_out   = '0;
    if (tick) begin
      if (lamp_power && mode_fade) begin
        result.red_out   = scaled_r;
        result.green_out = scaled_g;
        result.blue_out  = scaled_b;
        fade_level_next  = stepped;
        if (stepped == '0 || stepped == lfc_pkg::LEVEL_MAX) begin
          going_down_next = !going_down;
        end
      end else if (lamp_power) begin
        result.red_out   = chan_r;
        result.green_out = chan_g;
        result.blue_out  = chan_b;
      end
    end else if (!lamp_power) begin
      if (ir_code == lfc_pkg::CODE_ON) begin
        lamp_power_next = 1'b1;
      end
    end else begin
      unique case (ir_code)
        lfc_pkg::CODE_OFF:   lamp_power_next   = 1'b0;
        lfc_pkg::CODE_SOLID: mode_fade_next    = 1'b0;
        lfc_pkg::CODE_FADE:  mode_fade_next    = 1'b1;
        lfc_pkg::CODE_RED:   chosen_color_next = colors.red;
        lfc_pkg::CODE_GREEN: chosen_color_next = colors.green;
        lfc_pkg::CODE_BLUE:  chosen_color_next = colors.blue;
        lfc_pkg::CODE_WHITE: chosen_color_next = colors.white;
        default: ;
      endcase
    end
    result.frame_valid = tick;
    result.lamp_is_on  = lamp_power_next;
    result.fade_active = mode_fade_next;
  end

  // State update when the item moves on to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_power   <= 1'b0;
      mode_fade    <= 1'b0;
      fade_level   <= lfc_pkg::LEVEL_MAX;
      going_down   <= 1'b1;
      chosen_color <= lfc_pkg::RESET_RED;
    end else if (fire) begin
      lamp_power   <= lamp_power_next;
      mode_fade    <= mode_fade_next;
      fade_level   <= fade_level_next;
      going_down   <= going_down_next;
      chosen_color <= chosen_color_next;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_ir_remote_led_fade_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_remote_led_fade_controller: self-checking bench for the fade controller.
// Frame ticks and remote codes are sent in bursts through the input channel.
// A local copy of the lamp state predicts every fill color and status, and the
// result stream is checked field by field against it in order. The color
// registers are rewritten between phases with zero, full-scale and random
// values.
// ----------------------------------------------------------------------------
module tb_ir_remote_led_fade_controller;

  // Request type for a remote code, the counterpart of a frame tick.
  localparam logic REQ_IR = 1'b1;

  // Register indexes past the last color register; writes there are dropped.
  localparam logic [lfc_pkg::CFG_IDX_W-1:0] REG_BEYOND = 8'd4;
  localparam logic [lfc_pkg::CFG_IDX_W-1:0] REG_LAST   = 8'hFF;

  localparam int  DRAIN_CYCLES = 8;
  localparam int  HOLD_AT      = 400;
  localparam int  HOLD_CYCLES  = 400;
  localparam time TIMEOUT_NS   = 4_000_000;

  // Stall patterns of the result side.
  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_PERIODIC, RX_SLOW} rx_mode_e;

  typedef struct {
    logic                       rtype;
    logic [lfc_pkg::CODE_W-1:0] code;
  } remote_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic                          req_type  = lfc_pkg::REQ_TICK;
  logic [lfc_pkg::CODE_W-1:0]    ir_code   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          frame_valid;
  logic [lfc_pkg::CHAN_W-1:0]    red_out;
  logic [lfc_pkg::CHAN_W-1:0]    green_out;
  logic [lfc_pkg::CHAN_W-1:0]    blue_out;
  logic                          lamp_is_on;
  logic                          fade_active;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [lfc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lfc_pkg::COLOR_W-1:0]   cfg_data  = '0;

  // Items waiting to be sent and fills waiting to come out.
  remote_item_t     remote_items[$];
  lfc_pkg::result_t expected_fills[$];
  int               items_queued   = 0;
  int               items_taken    = 0;
  int               mismatch_count = 0;

  // Local copy of the lamp state and the color registers.
  lfc_pkg::color_set_t         color_regs;
  logic                        lamp_on;
  logic                        fade_on;
  logic [lfc_pkg::CHAN_W-1:0]  level;
  logic                        dimming;
  logic [lfc_pkg::COLOR_W-1:0] chosen;

  always #4 clk = ~clk;

  ir_remote_led_fade_controller DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .ir_code     (ir_code),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_valid (frame_valid),
    .red_out     (red_out),
    .green_out   (green_out),
    .blue_out    (blue_out),
    .lamp_is_on  (lamp_is_on),
    .fade_active (fade_active),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Scales one channel by level/255, truncating.
  function automatic logic [lfc_pkg::CHAN_W-1:0] scale_chan(
      input logic [lfc_pkg::CHAN_W-1:0] chan, input logic [lfc_pkg::CHAN_W-1:0] lvl);
    logic [2*lfc_pkg::CHAN_W-1:0] prod;
    prod = chan * lvl;
    return lfc_pkg::CHAN_W'(prod / lfc_pkg::LEVEL_MAX);
  endfunction

  // Works out the result of one item and advances the local lamp state.
  function automatic lfc_pkg::result_t predict_fill(input logic rtype,
                                                    input logic [lfc_pkg::CODE_W-1:0] code);
    lfc_pkg::result_t res;
    res = '0;
    res.frame_valid = (rtype == lfc_pkg::REQ_TICK);
    if (rtype == lfc_pkg::REQ_TICK) begin
      if (lamp_on && fade_on) begin
        res.red_out   = scale_chan(chosen[23:16], level);
        res.green_out = scale_chan(chosen[15:8], level);
        res.blue_out  = scale_chan(chosen[7:0], level);
        // The level saturates at both ends and turns around when it hits one.
        if (dimming) begin
          level = (level < lfc_pkg::LEVEL_STEP) ? '0 : level - lfc_pkg::LEVEL_STEP;
        end else begin
          level = (level > lfc_pkg::LEVEL_MAX - lfc_pkg::LEVEL_STEP) ?
                  lfc_pkg::LEVEL_MAX : level + lfc_pkg::LEVEL_STEP;
        end
        if (level == '0 || level == lfc_pkg::LEVEL_MAX) begin
          dimming = ~dimming;
        end
      end else if (lamp_on) begin
        {res.red_out, res.green_out, res.blue_out} = chosen;
      end
    end else if (!lamp_on) begin
      // While off, only the on-code does anything.
      if (code == lfc_pkg::CODE_ON) begin
        lamp_on = 1'b1;
      end
    end else begin
      case (code)
        lfc_pkg::CODE_OFF:   lamp_on = 1'b0;
        lfc_pkg::CODE_SOLID: fade_on = 1'b0;
        lfc_pkg::CODE_FADE:  fade_on = 1'b1;
        lfc_pkg::CODE_RED:   chosen  = color_regs.red;
        lfc_pkg::CODE_GREEN: chosen  = color_regs.green;
        lfc_pkg::CODE_BLUE:  chosen  = color_regs.blue;
        lfc_pkg::CODE_WHITE: chosen  = color_regs.white;
        default: ;
      endcase
    end
    res.lamp_is_on  = lamp_on;
    res.fade_active = fade_on;
    return res;
  endfunction

  function automatic logic [lfc_pkg::CODE_W-1:0] button_code(input int idx);
    case (idx)
      0:       return lfc_pkg::CODE_OFF;
      1:       return lfc_pkg::CODE_SOLID;
      2:       return lfc_pkg::CODE_FADE;
      3:       return lfc_pkg::CODE_RED;
      4:       return lfc_pkg::CODE_GREEN;
      5:       return lfc_pkg::CODE_BLUE;
      6:       return lfc_pkg::CODE_WHITE;
      default: return lfc_pkg::CODE_ON;
    endcase
  endfunction

  // Driver: sends queued items in bursts and predicts each accepted one.
  int           burst_left = 1;
  int           gap_left   = 0;
  remote_item_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      lamp_on          = 1'b0;
      fade_on          = 1'b0;
      level            = lfc_pkg::LEVEL_MAX;
      dimming          = 1'b1;
      chosen           = lfc_pkg::RESET_RED;
      color_regs.red   = lfc_pkg::RESET_RED;
      color_regs.green = lfc_pkg::RESET_GREEN;
      color_regs.blue  = lfc_pkg::RESET_BLUE;
      color_regs.white = lfc_pkg::RESET_WHITE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lfc_pkg::REG_RED:   color_regs.red   = cfg_data;
          lfc_pkg::REG_GREEN: color_regs.green = cfg_data;
          lfc_pkg::REG_BLUE:  color_regs.blue  = cfg_data;
          lfc_pkg::REG_WHITE: color_regs.white = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        expected_fills.push_back(predict_fill(req_type, ir_code));
        items_taken++;
      end
      // A new item goes out only once the current one has been taken.
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (remote_items.size() != 0) begin
          next_item = remote_items.pop_front();
          in_valid <= 1'b1;
          req_type <= next_item.rtype;
          ir_code  <= next_item.code;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: changing stall patterns, plus one long hold-off that lets
  // the block fill up and push back on the input.
  rx_mode_e rx_mode    = RX_FREE;
  int       mode_left  = 0;
  int       hold_left  = 0;
  logic     hold_done  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && items_taken >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:     out_ready <= 1'b1;
          RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_ready <= (mode_left % 3 != 0);
          default:     out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic check_field(input string fname, input logic [lfc_pkg::CHAN_W-1:0] want,
                             input logic [lfc_pkg::CHAN_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
    end
  endtask

  // Monitor: each result transfer is compared with the oldest prediction.
  lfc_pkg::result_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_fills.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, expected nothing, actual %0h", $time,
                 {frame_valid, red_out, green_out, blue_out, lamp_is_on, fade_active});
      end else begin
        want = expected_fills.pop_front();
        check_field("frame_valid", lfc_pkg::CHAN_W'(want.frame_valid),
                    lfc_pkg::CHAN_W'(frame_valid));
        check_field("red_out", want.red_out, red_out);
        check_field("green_out", want.green_out, green_out);
        check_field("blue_out", want.blue_out, blue_out);
        check_field("lamp_is_on", lfc_pkg::CHAN_W'(want.lamp_is_on),
                    lfc_pkg::CHAN_W'(lamp_is_on));
        check_field("fade_active", lfc_pkg::CHAN_W'(want.fade_active),
                    lfc_pkg::CHAN_W'(fade_active));
      end
    end
  end

  task automatic add_item(input logic rtype, input logic [lfc_pkg::CODE_W-1:0] code);
    remote_item_t item;
    item.rtype = rtype;
    item.code  = code;
    remote_items.push_back(item);
    items_queued++;
  endtask

  // Mostly well-formed button sequences with runs of ticks, some lone
  // buttons, and some noise codes.
  task automatic add_random(input int count);
    int target;
    int kind;
    int ticks;
    target = items_queued + count;
    while (items_queued < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        if ($urandom_range(0, 3) != 0) add_item(REQ_IR, lfc_pkg::CODE_ON);
        add_item(REQ_IR, $urandom_range(0, 1) ? lfc_pkg::CODE_FADE : lfc_pkg::CODE_SOLID);
        if ($urandom_range(0, 2) != 0) add_item(REQ_IR, button_code($urandom_range(3, 6)));
        // Long runs can sweep the fade level through both turning points.
        ticks = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 110) : $urandom_range(1, 12);
        repeat (ticks) add_item(lfc_pkg::REQ_TICK, $urandom());
        if ($urandom_range(0, 3) == 0) add_item(REQ_IR, lfc_pkg::CODE_OFF);
      end else if (kind < 75) begin
        add_item(REQ_IR, button_code($urandom_range(0, 7)));
      end else if (kind < 85) begin
        if ($urandom_range(0, 1)) begin
          add_item(REQ_IR, $urandom());
        end else begin
          add_item(REQ_IR, button_code($urandom_range(0, 7)) ^ (32'd1 << $urandom_range(0, 31)));
        end
      end else begin
        add_item(lfc_pkg::REQ_TICK, $urandom());
      end
    end
  endtask

  // Holds one register write until it is taken; the caller lowers cfg_valid.
  task automatic write_reg(input logic [lfc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lfc_pkg::COLOR_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_colors(input logic [lfc_pkg::COLOR_W-1:0] r,
                            input logic [lfc_pkg::COLOR_W-1:0] g,
                            input logic [lfc_pkg::COLOR_W-1:0] b,
                            input logic [lfc_pkg::COLOR_W-1:0] w);
    write_reg(lfc_pkg::REG_RED, r);
    write_reg(lfc_pkg::REG_GREEN, g);
    write_reg(lfc_pkg::REG_BLUE, b);
    write_reg(lfc_pkg::REG_WHITE, w);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every queued item has been taken and every result has come.
  task automatic drain();
    while (items_taken != items_queued || expected_fills.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset colors.
    add_item(lfc_pkg::REQ_TICK, lfc_pkg::CODE_ON);
    add_item(REQ_IR, lfc_pkg::CODE_FADE);
    add_item(REQ_IR, lfc_pkg::CODE_OFF);
    add_item(REQ_IR, lfc_pkg::CODE_ON);
    add_item(REQ_IR, lfc_pkg::CODE_ON);
    add_item(lfc_pkg::REQ_TICK, 32'hFFFF_FFFF);
    add_item(REQ_IR, lfc_pkg::CODE_GREEN);
    add_item(lfc_pkg::REQ_TICK, 32'h0);
    add_item(REQ_IR, lfc_pkg::CODE_BLUE);
    add_item(REQ_IR, lfc_pkg::CODE_WHITE);
    add_item(lfc_pkg::REQ_TICK, 32'h0);
    add_item(REQ_IR, lfc_pkg::CODE_RED);
    add_item(REQ_IR, 32'h0);
    add_item(REQ_IR, 32'hFFFF_FFFF);
    add_item(REQ_IR, lfc_pkg::CODE_FADE);
    add_item(lfc_pkg::REQ_TICK, 32'h0);
    add_item(lfc_pkg::REQ_TICK, 32'h0);
    add_item(REQ_IR, lfc_pkg::CODE_SOLID);
    add_item(lfc_pkg::REQ_TICK, 32'h0);
    add_item(REQ_IR, lfc_pkg::CODE_FADE);
    add_item(lfc_pkg::REQ_TICK, 32'h0);
    add_item(REQ_IR, lfc_pkg::CODE_OFF);
    add_item(lfc_pkg::REQ_TICK, 32'h0);
    add_item(REQ_IR, lfc_pkg::CODE_ON);
    add_item(lfc_pkg::REQ_TICK, 32'h0);
    drain();

    // All colors black; the first tick still shows the color chosen earlier.
    set_colors(24'h000000, 24'h000000, 24'h000000, 24'h000000);
    add_item(lfc_pkg::REQ_TICK, $urandom());
    add_random(60);
    drain();

    // All colors full scale, plus writes past the last register.
    write_reg(REG_BEYOND, lfc_pkg::COLOR_W'($urandom()));
    write_reg(REG_LAST, lfc_pkg::COLOR_W'($urandom()));
    set_colors(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    add_item(lfc_pkg::REQ_TICK, $urandom());
    add_random(60);
    drain();

    // Random colors for the bulk of the run.
    set_colors(lfc_pkg::COLOR_W'($urandom()), lfc_pkg::COLOR_W'($urandom()),
               lfc_pkg::COLOR_W'($urandom()), lfc_pkg::COLOR_W'($urandom()));
    add_item(lfc_pkg::REQ_TICK, $urandom());
    add_random(1500);
    drain();

    // Mixed single-channel extremes.
    set_colors(24'h0000FF, 24'hFF00FF, 24'h000001, lfc_pkg::COLOR_W'($urandom()));
    add_item(lfc_pkg::REQ_TICK, $urandom());
    add_random(250);
    drain();

    if (mismatch_count == 0 && expected_fills.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lfc_pkg.sv
hdl/lfc_cfg_regs.sv
hdl/lfc_core.sv
hdl/ir_remote_led_fade_controller.sv
verif/tb_ir_remote_led_fade_controller.sv
